>>> src/bcm_pkg.sv
// Shared types and constants for the battery cell monitor.
// No dependencies; imported by bcm_therm_rom and battery_cell_monitor_unit.
`timescale 1ns / 1ps

package bcm_pkg;

    // Fixed field widths
    localparam int RAW_W = 10;
    localparam int CFG_W = 14;
    localparam int C1_W  = 14;
    localparam int C2_W  = 15;
    localparam int T_W   = 17;
    localparam int ROW_W = C1_W + C2_W + T_W + T_W;
    localparam int ADC_MAX_W = 12;

    // Configuration port
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_CELL_FS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PACK_FS = 2'd1;
    localparam logic [CFG_W-1:0] CELL_FS_RESET = 14'd5200;
    localparam logic [CFG_W-1:0] PACK_FS_RESET = 14'd10000;

    // Item opcodes
    localparam logic OP_PUSH    = 1'b0;
    localparam logic OP_PUBLISH = 1'b1;

    // Thermistor conversion constants
    localparam longint LN2_Q30   = 744261118;
    localparam longint BETA_X100 = 338000;
    localparam longint T0_CK     = 29815;
    localparam longint ZERO_C_CK = 27315;
    localparam longint TEMP_MAX  = 50000;
    localparam longint TEMP_MIN  = -27315;
    localparam int     FRAC_BITS = 24;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PUSH_T2,
        ST_PUSH_WR,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_HOLD
    } state_t;

endpackage

>>> src/bcm_therm_rom.sv
// Thermistor reading to centi-degree lookup, built at elaboration.
// Depends on bcm_pkg for widths and beta-equation constants.
`timescale 1ns / 1ps

module bcm_therm_rom #(
    parameter int ADC_BITS = 10
) (
    input  logic                         clk,
    input  logic [ADC_BITS-1:0]          addr,
    output logic signed [bcm_pkg::T_W-1:0] data
);
    import bcm_pkg::*;

    localparam int TBL_DEPTH = 1 << ADC_BITS;

    typedef logic [T_W-1:0] tbl_t [TBL_DEPTH];

    // Bit-by-bit log2 in Q24
    function automatic longint log2_q24(longint m);
        longint     k;
        longint     t;
        logic [63:0] y;
        longint     frac;
        k = 0;
        t = m;
        while (t > 1) begin
            t = t >>> 1;
            k = k + 1;
        end
        y = 64'(m) << (30 - k);
        frac = 0;
        for (int i = FRAC_BITS - 1; i >= 0; i--) begin
            y = (y * y) >> 30;
            if (y >= 64'h8000_0000) begin
                y = y >> 1;
                frac = frac | (longint'(1) << i);
            end
        end
        return (k << FRAC_BITS) | frac;
    endfunction

    // Restoring unsigned divide
    function automatic logic [63:0] udiv64(logic [63:0] a, logic [63:0] b);
        logic [64:0] rem;
        logic [63:0] q;
        rem = '0;
        q   = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[63:0], a[i]};
            if (rem >= {1'b0, b}) begin
                rem  = rem - {1'b0, b};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [T_W-1:0] therm_centi(longint r);
        longint n;
        longint d;
        longint mag;
        longint lq;
        longint den;
        longint num;
        longint tk;
        longint c;
        n = longint'(1) << ADC_BITS;
        if (r == 0) begin
            return T_W'(TEMP_MIN);
        end
        d   = log2_q24(n - r) - log2_q24(r);
        mag = ((d < 0) ? -d : d) * LN2_Q30;
        mag = (mag + (longint'(1) << 29)) >>> 30;
        lq  = (d < 0) ? -mag : mag;
        den = BETA_X100 * (longint'(1) << FRAC_BITS) + T0_CK * lq;
        if (den <= 0) begin
            return T_W'(TEMP_MAX);
        end
        num = BETA_X100 * T0_CK * (longint'(1) << FRAC_BITS);
        tk  = longint'(udiv64(64'(num + (den >>> 1)), 64'(den)));
        c   = tk - ZERO_C_CK;
        if (c > TEMP_MAX) c = TEMP_MAX;
        if (c < TEMP_MIN) c = TEMP_MIN;
        return T_W'(c);
    endfunction

    function automatic tbl_t build_tbl();
        tbl_t t;
        for (int i = 0; i < TBL_DEPTH; i++) begin
            t[i] = therm_centi(longint'(i));
        end
        return t;
    endfunction

    localparam tbl_t TEMP_TBL = build_tbl();

    // Registered lookup
    always_ff @(posedge clk)
    begin
        data <= $signed(TEMP_TBL[addr]);
    end

endmodule

>>> src/bcm_divider.sv
// Bit-serial signed-by-unsigned divider, truncating toward zero.
// Self-contained; sized entirely by its parameters.
`timescale 1ns / 1ps

module bcm_divider #(
    parameter int NUM_W = 22,
    parameter int DEN_W = 5
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [NUM_W-1:0] num,
    input  logic [DEN_W-1:0]        den,
    output logic                    done,
    output logic signed [NUM_W-1:0] quot
);
    localparam int STEP_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [NUM_W-1:0]  acc_reg;
    logic [DEN_W-1:0]  rem_reg;
    logic              neg_reg;

    logic [DEN_W:0]    shifted;
    logic [DEN_W:0]    diff;
    logic              ge;

    // One quotient bit per cycle
    assign shifted = {rem_reg, acc_reg[NUM_W-1]};
    assign ge      = shifted >= {1'b0, den};
    assign diff    = shifted - {1'b0, den};

    // Sequence control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(NUM_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: load magnitude, then shift and subtract
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= num[NUM_W-1];
            acc_reg <= num[NUM_W-1] ? (~num + 1'b1) : num;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            acc_reg <= {acc_reg[NUM_W-2:0], ge};
            rem_reg <= ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
        end
    end

    assign done = done_reg;
    assign quot = neg_reg ? $signed(~acc_reg + 1'b1) : $signed(acc_reg);

endmodule

>>> src/battery_cell_monitor_unit.sv
// Two-cell battery monitor: voltage scaling, thermistor lookup, window averages.
// Depends on bcm_pkg, bcm_therm_rom and bcm_divider.
//
// Channels: an input stream (in_valid/in_ready) carrying opcode and four ADC
// readings, a result stream (out_valid/out_ready) carrying four averages and
// the sample count, and a configuration write channel (cfg_valid/cfg_ready,
// cfg_index, cfg_data) that is always ready; the user writes it only while idle, and the block has no check for this.
// On a push beat the readings are scaled, the window row at the
// write slot is read from the window memory, the two thermistor values come
// from the shared lookup ROM one per cycle, and the new row is written back
// while the running sums drop the evicted row.
// A publish beat runs the bit-serial divider once per channel, and the
// divider sets the publish time. An empty window publishes zeros.
// Results sit in an output register; a stalled receiver holds them while
// pushes keep being accepted, and a later publish waits for the register.
// Reset empties the window (count and slot zero, sums zero) and restores the
// full-scale registers; the window memory itself is not cleared.
`timescale 1ns / 1ps

module battery_cell_monitor_unit #(
    parameter int WINDOW   = 20,
    parameter int ADC_BITS = 10
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              opcode,
    input  logic [bcm_pkg::RAW_W-1:0]         cell_one_raw,
    input  logic [bcm_pkg::RAW_W-1:0]         pack_raw,
    input  logic [bcm_pkg::RAW_W-1:0]         therm_one_raw,
    input  logic [bcm_pkg::RAW_W-1:0]         therm_two_raw,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [bcm_pkg::C1_W-1:0]          avg_cell_one_mv,
    output logic signed [bcm_pkg::C2_W-1:0]   avg_cell_two_mv,
    output logic signed [bcm_pkg::T_W-1:0]    avg_temp_one,
    output logic signed [bcm_pkg::T_W-1:0]    avg_temp_two,
    output logic [4:0]                        samples_held,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [bcm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bcm_pkg::CFG_W-1:0]         cfg_data
);
    import bcm_pkg::*;

    localparam int FILL_W = $clog2(WINDOW + 1);
    localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int SUM_W  = T_W + FILL_W;
    localparam int PROD_W = ADC_BITS + CFG_W;

    state_t state_reg;
    state_t state_next;

    logic [CFG_W-1:0]  cell_fs_reg;
    logic [CFG_W-1:0]  pack_fs_reg;
    logic [SLOT_W-1:0] write_slot_reg;
    logic [FILL_W-1:0] fill_count_reg;
    logic signed [SUM_W-1:0] sum_reg [4];
    logic signed [SUM_W-1:0] q_reg [4];
    logic [1:0]        ch_reg;

    logic [ROW_W-1:0]  win_mem [WINDOW];
    logic [ROW_W-1:0]  mem_rd_reg;

    logic [C1_W-1:0]   c1_reg;
    logic [C1_W-1:0]   pk_reg;
    logic signed [T_W-1:0] t1_reg;
    logic [ADC_BITS-1:0]   t2_raw_reg;

    logic [ADC_MAX_W-1:0] c1_ext;
    logic [ADC_MAX_W-1:0] pk_ext;
    logic [ADC_MAX_W-1:0] t1_ext;
    logic [ADC_MAX_W-1:0] t2_ext;
    logic [PROD_W-1:0]    c1_prod;
    logic [PROD_W-1:0]    pk_prod;

    logic [ADC_BITS-1:0]   rom_addr;
    logic signed [T_W-1:0] rom_data;

    logic                  div_start;
    logic                  div_done;
    logic signed [SUM_W-1:0] div_quot;

    logic                  in_accept;
    logic                  load_out;
    logic                  full;
    logic signed [C2_W-1:0] c2_new;
    logic [ROW_W-1:0]      row_new;
    logic [C1_W-1:0]       old_c1;
    logic signed [C2_W-1:0] old_c2;
    logic signed [T_W-1:0] old_t1;
    logic signed [T_W-1:0] old_t2;

    logic              out_valid_reg;
    logic [C1_W-1:0]   out_c1_reg;
    logic [C2_W-1:0]   out_c2_reg;
    logic [T_W-1:0]    out_t1_reg;
    logic [T_W-1:0]    out_t2_reg;
    logic [4:0]        out_cnt_reg;

    // Low ADC_BITS of each reading
    assign c1_ext = ADC_MAX_W'(cell_one_raw);
    assign pk_ext = ADC_MAX_W'(pack_raw);
    assign t1_ext = ADC_MAX_W'(therm_one_raw);
    assign t2_ext = ADC_MAX_W'(therm_two_raw);
    assign c1_prod = PROD_W'(c1_ext[ADC_BITS-1:0]) * PROD_W'(cell_fs_reg);
    assign pk_prod = PROD_W'(pk_ext[ADC_BITS-1:0]) * PROD_W'(pack_fs_reg);

    assign in_accept = in_valid && in_ready;
    assign full      = fill_count_reg == FILL_W'(WINDOW);
    assign load_out  = (state_reg == ST_HOLD) && (!out_valid_reg || out_ready);

    // Thermistor lookup shared by both channels
    assign rom_addr = (state_reg == ST_IDLE) ? t1_ext[ADC_BITS-1:0] : t2_raw_reg;

    bcm_therm_rom #(
        .ADC_BITS(ADC_BITS)
    ) u_rom (
        .clk (clk),
        .addr(rom_addr),
        .data(rom_data)
    );

    bcm_divider #(
        .NUM_W(SUM_W),
        .DEN_W(FILL_W)
    ) u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .start(div_start),
        .num  (sum_reg[ch_reg]),
        .den  (fill_count_reg),
        .done (div_done),
        .quot (div_quot)
    );

    // Next state and control
    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        div_start  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (opcode == OP_PUBLISH)
                        state_next = (fill_count_reg == '0) ? ST_HOLD : ST_DIV_START;
                    else
                        state_next = ST_PUSH_T2;
                end
            end
            ST_PUSH_T2:   state_next = ST_PUSH_WR;
            ST_PUSH_WR:   state_next = ST_IDLE;
            ST_DIV_START:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (div_done)
                    state_next = (ch_reg == 2'd3) ? ST_HOLD : ST_DIV_START;
            end
            ST_HOLD:
            begin
                if (load_out)
                    state_next = ST_IDLE;
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Window memory: read the slot on push, write the new row back
    assign old_c1 = mem_rd_reg[ROW_W-1 -: C1_W];
    assign old_c2 = $signed(mem_rd_reg[ROW_W-C1_W-1 -: C2_W]);
    assign old_t1 = $signed(mem_rd_reg[2*T_W-1 -: T_W]);
    assign old_t2 = $signed(mem_rd_reg[T_W-1:0]);
    assign c2_new = $signed({1'b0, pk_reg}) - $signed({1'b0, c1_reg});
    assign row_new = {c1_reg, c2_new, t1_reg, rom_data};

    always_ff @(posedge clk)
    begin
        if (in_accept && opcode == OP_PUSH)
            mem_rd_reg <= win_mem[write_slot_reg];
        if (state_reg == ST_PUSH_WR)
            win_mem[write_slot_reg] <= row_new;
    end

    // Capture scaled readings and thermistor values
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            c1_reg     <= c1_prod[PROD_W-1 -: C1_W];
            pk_reg     <= pk_prod[PROD_W-1 -: C1_W];
            t2_raw_reg <= t2_ext[ADC_BITS-1:0];
        end
        if (state_reg == ST_PUSH_T2)
            t1_reg <= rom_data;
    end

    // Configuration, slot, count and running sums
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_fs_reg    <= CELL_FS_RESET;
            pack_fs_reg    <= PACK_FS_RESET;
            write_slot_reg <= '0;
            fill_count_reg <= '0;
            for (int i = 0; i < 4; i++)
                sum_reg[i] <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_CELL_FS: cell_fs_reg <= cfg_data;
                    REG_PACK_FS: pack_fs_reg <= cfg_data;
                    default:     ;
                endcase
            end
            if (state_reg == ST_PUSH_WR)
            begin
                sum_reg[0] <= sum_reg[0] + SUM_W'($signed({1'b0, c1_reg}))
                              - (full ? SUM_W'($signed({1'b0, old_c1})) : '0);
                sum_reg[1] <= sum_reg[1] + SUM_W'(c2_new)
                              - (full ? SUM_W'(old_c2) : '0);
                sum_reg[2] <= sum_reg[2] + SUM_W'(t1_reg)
                              - (full ? SUM_W'(old_t1) : '0);
                sum_reg[3] <= sum_reg[3] + SUM_W'(rom_data)
                              - (full ? SUM_W'(old_t2) : '0);
                if (write_slot_reg == SLOT_W'(WINDOW - 1))
                    write_slot_reg <= '0;
                else
                    write_slot_reg <= write_slot_reg + 1'b1;
                if (!full)
                    fill_count_reg <= fill_count_reg + 1'b1;
            end
        end
    end

    assign cfg_ready = 1'b1;

    // Publish: walk the four channels through the divider
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ch_reg <= '0;
        else if (in_accept)
            ch_reg <= '0;
        else if (div_done)
            ch_reg <= ch_reg + 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept && opcode == OP_PUBLISH)
        begin
            for (int i = 0; i < 4; i++)
                q_reg[i] <= '0;
        end
        else if (div_done)
            q_reg[ch_reg] <= div_quot;
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load_out)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_c1_reg  <= q_reg[0][C1_W-1:0];
            out_c2_reg  <= q_reg[1][C2_W-1:0];
            out_t1_reg  <= q_reg[2][T_W-1:0];
            out_t2_reg  <= q_reg[3][T_W-1:0];
            out_cnt_reg <= 5'(fill_count_reg);
        end
    end

    assign out_valid       = out_valid_reg;
    assign avg_cell_one_mv = out_c1_reg;
    assign avg_cell_two_mv = $signed(out_c2_reg);
    assign avg_temp_one    = $signed(out_t1_reg);
    assign avg_temp_two    = $signed(out_t2_reg);
    assign samples_held    = out_cnt_reg;

    // Checks
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_count_reg <= FILL_W'(WINDOW))
        else $error("fill count beyond window");

    a_slot_tracks_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_count_reg < FILL_W'(WINDOW)) |-> (FILL_W'(write_slot_reg) == fill_count_reg))
        else $error("write slot out of step with fill count");

    a_publish_divides: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && opcode == OP_PUBLISH && fill_count_reg != '0)
        |=> (state_reg == ST_DIV_START))
        else $error("publish did not start division");

    a_out_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> !$past(load_out))
        else $error("output register overwritten while stalled");

endmodule
